FILE: src/gift64_pkg.sv
package gift64_pkg;

    localparam int BLOCK_W = 64;
    localparam int KEY_W   = 128;
    localparam int RK_W    = 32;
    localparam int ROUND_W = 5;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 64;
    localparam int NUM_RCON = 28;

    // register index, taken from paddr[4:3]
    localparam logic [1:0] REG_KEY_HIGH    = 2'd0;
    localparam logic [1:0] REG_KEY_LOW     = 2'd1;
    localparam logic [1:0] REG_ROUND_COUNT = 2'd2;

    localparam logic [ROUND_W-1:0] ROUND_COUNT_RST = 5'd28;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [ROUND_W-1:0] rounds;
    } cfg_t;

    localparam logic [3:0] SBOX [16] = '{
        4'h1, 4'ha, 4'h4, 4'hc, 4'h6, 4'hf, 4'h3, 4'h9,
        4'h2, 4'hd, 4'hb, 4'h7, 4'h5, 4'h0, 4'h8, 4'he
    };

    localparam logic [5:0] RCON [NUM_RCON] = '{
        6'h01, 6'h03, 6'h07, 6'h0F, 6'h1F, 6'h3E, 6'h3D, 6'h3B, 6'h37, 6'h2F,
        6'h1E, 6'h3C, 6'h39, 6'h33, 6'h27, 6'h0E, 6'h1D, 6'h3A, 6'h35, 6'h2B,
        6'h16, 6'h2C, 6'h18, 6'h30, 6'h21, 6'h02, 6'h05, 6'h0B
    };

    function automatic logic [BLOCK_W-1:0] sub_nibbles(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        y = '0;
        for (int n = 0; n < 16; n++) begin
            y[4*n +: 4] = SBOX[x[4*n +: 4]];
        end
        return y;
    endfunction

    // fixed bit permutation: pure wiring
    function automatic logic [BLOCK_W-1:0] perm_bits(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        int grp;
        int pos;
        int bt;
        int dst;
        y = '0;
        for (int i = 0; i < 64; i++) begin
            grp = i >> 4;
            pos = (i >> 2) & 3;
            bt  = i & 3;
            dst = 4 * grp + 16 * ((3 * pos + bt) & 3) + bt;
            y[dst[5:0]] = x[i];
        end
        return y;
    endfunction

    function automatic logic [BLOCK_W-1:0] add_const(input logic [BLOCK_W-1:0] x,
                                                     input logic [5:0] c);
        logic [BLOCK_W-1:0] y;
        y = x;
        y[63] = ~y[63];
        y[23] = y[23] ^ c[5];
        y[19] = y[19] ^ c[4];
        y[15] = y[15] ^ c[3];
        y[11] = y[11] ^ c[2];
        y[7]  = y[7]  ^ c[1];
        y[3]  = y[3]  ^ c[0];
        return y;
    endfunction

    function automatic logic [BLOCK_W-1:0] add_round_key(input logic [BLOCK_W-1:0] x,
                                                         input logic [RK_W-1:0] rk);
        logic [BLOCK_W-1:0] y;
        y = x;
        for (int i = 0; i < 16; i++) begin
            y[4*i]   = y[4*i]   ^ rk[i];
            y[4*i+1] = y[4*i+1] ^ rk[16+i];
        end
        return y;
    endfunction

    function automatic logic [BLOCK_W-1:0] gift_round(input logic [BLOCK_W-1:0] x,
                                                      input logic [RK_W-1:0] rk,
                                                      input logic [5:0] c);
        return add_round_key(add_const(perm_bits(sub_nibbles(x)), c), rk);
    endfunction

    // key update: rotations and word moves only
    function automatic logic [KEY_W-1:0] next_key(input logic [KEY_W-1:0] k);
        logic [63:0] hi;
        logic [63:0] lo;
        logic [15:0] w1;
        logic [15:0] w0;
        hi = k[127:64];
        lo = k[63:0];
        w1 = lo[31:16];
        w0 = lo[15:0];
        return {w1[1:0], w1[15:2], w0[11:0], w0[15:12], hi[63:32], hi[31:0], lo[63:32]};
    endfunction

endpackage

FILE: src/gift64_cfg_regs.sv
module gift64_cfg_regs #(
    parameter int MAX_ROUNDS = 28
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gift64_pkg::ADDR_W-1:0]   paddr,
    input  logic [gift64_pkg::DATA_W-1:0]   pwdata,
    output logic [gift64_pkg::DATA_W-1:0]   prdata,
    output logic                            pready,
    output gift64_pkg::cfg_t                cfg
);

    localparam logic [gift64_pkg::ROUND_W-1:0] MAX_R = gift64_pkg::ROUND_W'(MAX_ROUNDS);

    logic [63:0]                      key_high_reg;
    logic [63:0]                      key_low_reg;
    logic [gift64_pkg::ROUND_W-1:0]   round_count_reg;
    logic                             wr_en;
    logic [1:0]                       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg    <= '0;
            key_low_reg     <= '0;
            round_count_reg <= gift64_pkg::ROUND_COUNT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                gift64_pkg::REG_KEY_HIGH:    key_high_reg    <= pwdata;
                gift64_pkg::REG_KEY_LOW:     key_low_reg     <= pwdata;
                gift64_pkg::REG_ROUND_COUNT: round_count_reg <= pwdata[gift64_pkg::ROUND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            gift64_pkg::REG_KEY_HIGH:    prdata = key_high_reg;
            gift64_pkg::REG_KEY_LOW:     prdata = key_low_reg;
            gift64_pkg::REG_ROUND_COUNT:
                prdata = {{(gift64_pkg::DATA_W-gift64_pkg::ROUND_W){1'b0}}, round_count_reg};
            default:                     prdata = '0;
        endcase
    end

    // counts above the pipeline depth run the full depth
    assign cfg.key    = {key_high_reg, key_low_reg};
    assign cfg.rounds = (round_count_reg > MAX_R) ? MAX_R : round_count_reg;

endmodule

FILE: src/gift64_round_stage.sv
module gift64_round_stage #(
    parameter int STAGE = 0
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [gift64_pkg::BLOCK_W-1:0]   in_block,
    input  logic [gift64_pkg::RK_W-1:0]      round_key,
    input  logic [gift64_pkg::ROUND_W-1:0]   rounds,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [gift64_pkg::BLOCK_W-1:0]   out_block
);

    localparam logic [gift64_pkg::ROUND_W-1:0] STAGE_IDX = gift64_pkg::ROUND_W'(STAGE);

    logic                            valid_reg;
    logic [gift64_pkg::BLOCK_W-1:0]  block_reg;
    logic [gift64_pkg::BLOCK_W-1:0]  block_next;

    assign in_ready = ~valid_reg | out_ready;

    // stages past the configured count pass the word unchanged
    always_comb begin
        if (STAGE_IDX < rounds) begin
            block_next = gift64_pkg::gift_round(in_block, round_key,
                                                gift64_pkg::RCON[STAGE]);
        end else begin
            block_next = in_block;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            block_reg <= block_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_block = block_reg;

endmodule

FILE: src/gift64_block_encrypt.sv
// GIFT-64 encryption pipeline, one cipher round per register stage.
// Every word passes through the whole pipeline from s_ accept to m_tvalid,
//   independent of round_count; stages beyond round_count pass the word on.
// Throughput: one word per cycle while m_tready is high; each stage holds its word while stalled
//   and an empty stage still accepts, so bubbles close up under back-pressure.
// Reset (aresetn, synchronous, active low): pipeline emptied, key = 0, round_count = 28.
module gift64_block_encrypt #(
    parameter int MAX_ROUNDS = 28
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [63:0]                      s_tdata,   // [63:0] plaintext
    // result words
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [63:0]                      m_tdata,   // [63:0] ciphertext
    // configuration: key_high @0x00, key_low @0x08, round_count @0x10
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gift64_pkg::ADDR_W-1:0]    paddr,
    input  logic [gift64_pkg::DATA_W-1:0]    pwdata,
    output logic [gift64_pkg::DATA_W-1:0]    prdata,
    output logic                             pready
);

    gift64_pkg::cfg_t cfg;

    // per-stage handshake; ready[i] is stage i's input side, valid[i] and block[i] its output
    logic [MAX_ROUNDS-1:0]             stage_valid;
    logic [MAX_ROUNDS-1:0]             stage_ready;
    logic [gift64_pkg::BLOCK_W-1:0]    stage_block [MAX_ROUNDS];
    // key schedule state for each round; only rotations, so plain wiring
    logic [gift64_pkg::KEY_W-1:0]      key_sched   [MAX_ROUNDS];

    gift64_cfg_regs #(
        .MAX_ROUNDS (MAX_ROUNDS)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The user must change the key only while the pipeline is empty; the block does not enforce it.
    // So every stage may take its round key straight from the register contents.
    assign key_sched[0] = cfg.key;

    for (genvar g = 1; g < MAX_ROUNDS; g++) begin : g_key
        assign key_sched[g] = gift64_pkg::next_key(key_sched[g-1]);
    end

    for (genvar g = 0; g < MAX_ROUNDS; g++) begin : g_stage
        logic                            up_valid;
        logic [gift64_pkg::BLOCK_W-1:0]  up_block;
        logic                            dn_ready;

        if (g == 0) begin : g_first
            assign up_valid = s_tvalid;
            assign up_block = s_tdata;
        end else begin : g_mid
            assign up_valid = stage_valid[g-1];
            assign up_block = stage_block[g-1];
        end

        if (g == MAX_ROUNDS - 1) begin : g_last
            assign dn_ready = m_tready;
        end else begin : g_inner
            assign dn_ready = stage_ready[g+1];
        end

        gift64_round_stage #(
            .STAGE (g)
        ) u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (up_valid),
            .in_ready  (stage_ready[g]),
            .in_block  (up_block),
            .round_key (key_sched[g][gift64_pkg::RK_W-1:0]),
            .rounds    (cfg.rounds),
            .out_valid (stage_valid[g]),
            .out_ready (dn_ready),
            .out_block (stage_block[g])
        );
    end

    assign s_tready = stage_ready[0];
    assign m_tvalid = stage_valid[MAX_ROUNDS-1];
    assign m_tdata  = stage_block[MAX_ROUNDS-1];

`ifndef ASSERT_OFF
    // an accepted word lands in the first stage
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> stage_valid[0])
        else $error("accepted word did not enter first stage");

    // full pipeline under back-pressure must refuse input
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (&stage_valid) && !m_tready |-> !s_tready)
        else $error("input accepted while pipeline full and stalled");

    // effective round count never exceeds the pipeline depth
    a_rounds_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cfg.rounds) <= MAX_ROUNDS)
        else $error("round count beyond pipeline depth");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_ROUNDS  = 28;
    // pipeline depth is MAX_ROUNDS stages whatever round_count says
    localparam int LATENCY     = MAX_ROUNDS;
    // cycles with no word moving on either side and no register access before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    localparam int N_PHASES    = 8;
    localparam int PHASE_WORDS = 235;

    localparam int AW = gift64_pkg::ADDR_W;
    localparam int DW = gift64_pkg::DATA_W;

    // index 3 decodes to nothing; writes there must leave the key and rounds alone
    localparam logic [1:0]    REG_UNUSED       = 2'd3;
    localparam logic [AW-1:0] ADDR_KEY_HIGH    = {gift64_pkg::REG_KEY_HIGH, 3'b000};
    localparam logic [AW-1:0] ADDR_KEY_LOW     = {gift64_pkg::REG_KEY_LOW, 3'b000};
    localparam logic [AW-1:0] ADDR_ROUND_COUNT = {gift64_pkg::REG_ROUND_COUNT, 3'b000};
    localparam logic [AW-1:0] ADDR_UNUSED      = {REG_UNUSED, 3'b000};

    localparam logic [3:0] NIBBLE_SUB [16] = '{
        4'h1, 4'ha, 4'h4, 4'hc, 4'h6, 4'hf, 4'h3, 4'h9,
        4'h2, 4'hd, 4'hb, 4'h7, 4'h5, 4'h0, 4'h8, 4'he
    };

    // six-bit LFSR constants, one per round
    localparam logic [5:0] ROUND_CONST [28] = '{
        6'h01, 6'h03, 6'h07, 6'h0f, 6'h1f, 6'h3e, 6'h3d, 6'h3b, 6'h37, 6'h2f,
        6'h1e, 6'h3c, 6'h39, 6'h33, 6'h27, 6'h0e, 6'h1d, 6'h3a, 6'h35, 6'h2b,
        6'h16, 6'h2c, 6'h18, 6'h30, 6'h21, 6'h02, 6'h05, 6'h0b
    };

    // round counts per random phase; the last entry is replaced by a random pick
    localparam logic [4:0] ROUND_PLAN [N_PHASES] = '{
        5'd28, 5'd7, 5'd1, 5'd28, 5'd14, 5'd0, 5'd31, 5'd7
    };

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;

    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [63:0]    s_tdata = '0;      // [63:0] plaintext
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [63:0]    m_tdata;           // [63:0] ciphertext

    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [AW-1:0]  paddr = '0;
    logic [DW-1:0]  pwdata = '0;
    logic [DW-1:0]  prdata;
    logic           pready;

    // predictor's copy of the register file
    logic [63:0]    cfg_key_high = '0;
    logic [63:0]    cfg_key_low = '0;
    logic [4:0]     cfg_round_count = gift64_pkg::ROUND_COUNT_RST;

    logic [63:0]    plaintext_q [$];
    logic [63:0]    ciphertext_q [$];

    int             send_idle_pct = 25;
    int             recv_idle_pct = 25;
    logic           word_taken = 1'b0;
    int             mismatch_count = 0;
    int             quiet_cycles = 0;

    gift64_block_encrypt #(
        .MAX_ROUNDS(MAX_ROUNDS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // GIFT-64 encryption of one block: S-box layer, bit permutation, constant,
    // round key, then the rotating key update; counts over 28 are clamped
    function automatic logic [63:0] gift_encrypt(input logic [63:0] pt,
                                                 input logic [63:0] kh_in,
                                                 input logic [63:0] kl_in,
                                                 input logic [4:0]  rc);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] kh;
        logic [63:0] kl;
        logic [15:0] w1;
        logic [15:0] w0;
        int          rounds;
        int          dst;
        x = pt;
        kh = kh_in;
        kl = kl_in;
        rounds = (rc > MAX_ROUNDS) ? MAX_ROUNDS : int'(rc);
        for (int r = 0; r < rounds; r++) begin
            for (int n = 0; n < 16; n++) begin
                x[4*n +: 4] = NIBBLE_SUB[x[4*n +: 4]];
            end
            y = '0;
            for (int i = 0; i < 64; i++) begin
                dst = 4 * (i / 16) + 16 * ((3 * ((i % 16) / 4) + i % 4) % 4) + i % 4;
                y[dst] = x[i];
            end
            x = y;
            x[63] = ~x[63];
            x[23] = x[23] ^ ROUND_CONST[r][5];
            x[19] = x[19] ^ ROUND_CONST[r][4];
            x[15] = x[15] ^ ROUND_CONST[r][3];
            x[11] = x[11] ^ ROUND_CONST[r][2];
            x[7]  = x[7]  ^ ROUND_CONST[r][1];
            x[3]  = x[3]  ^ ROUND_CONST[r][0];
            // round key is the low 32 bits of the key: U on bit 4i+1, V on bit 4i
            for (int i = 0; i < 16; i++) begin
                x[4*i]   = x[4*i]   ^ kl[i];
                x[4*i+1] = x[4*i+1] ^ kl[16+i];
            end
            w1 = kl[31:16];
            w0 = kl[15:0];
            {kh, kl} = {w1[1:0], w1[15:2], w0[11:0], w0[15:12], kh, kl[63:32]};
        end
        return x;
    endfunction

    // Sender: a new word is offered only once the current one has gone,
    // so tvalid never drops while a word is waiting.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            if (plaintext_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tdata  <= plaintext_q.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: checks each delivered ciphertext word against the oldest
    // prediction, and predicts for every plaintext word taken at this edge.
    always @(posedge aclk) begin
        logic [63:0] want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (ciphertext_q.size() == 0) begin
                    $error("ciphertext: no word expected, got %h", m_tdata);
                    mismatch_count++;
                end else begin
                    want = ciphertext_q.pop_front();
                    if (m_tdata !== want) begin
                        $error("ciphertext: expected %h, got %h", want, m_tdata);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                ciphertext_q.push_back(gift_encrypt(s_tdata, cfg_key_high, cfg_key_low,
                                                    cfg_round_count));
            end
        end
        word_taken <= aresetn && s_tvalid && s_tready;
    end

    // Watchdog: gives up once quiet_cycles reaches STALL_LIMIT with nothing moving
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // APB write: setup cycle, then access cycle held until pready
    task automatic reg_write(input logic [AW-1:0] addr, input logic [DW-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr[4:3])
            gift64_pkg::REG_KEY_HIGH:    cfg_key_high = data;
            gift64_pkg::REG_KEY_LOW:     cfg_key_low = data;
            gift64_pkg::REG_ROUND_COUNT: cfg_round_count = data[4:0];
            default: ;
        endcase
    endtask

    task automatic set_cipher(input logic [63:0] kh, input logic [63:0] kl,
                              input logic [DW-1:0] rc);
        reg_write(ADDR_KEY_HIGH, kh);
        reg_write(ADDR_KEY_LOW, kl);
        reg_write(ADDR_ROUND_COUNT, rc);
    endtask

    // Hold off until every word sent has come back and the pipe has emptied;
    // checked at the rising edge, where the sender's queue and tvalid agree
    task automatic drain_pipe();
        while (plaintext_q.size() != 0 || s_tvalid || ciphertext_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic queue_random_words(input int count);
        logic [63:0] pt;
        for (int k = 0; k < count; k++) begin
            pt = {$urandom, $urandom};
            // now and then a lone set bit or a lone clear bit
            case ($urandom_range(0, 15))
                0: pt = 64'd1 << $urandom_range(0, 63);
                1: pt = ~(64'd1 << $urandom_range(0, 63));
                default: ;
            endcase
            plaintext_q.push_back(pt);
        end
    endtask

    initial begin
        logic [4:0] rc;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed, under the reset settings: zero key, full 28 rounds.
        // Blank and full blocks, every S-box input across the nibbles, alternating bits.
        plaintext_q.push_back(64'h0000_0000_0000_0000);
        plaintext_q.push_back(64'hffff_ffff_ffff_ffff);
        plaintext_q.push_back(64'h0123_4567_89ab_cdef);
        plaintext_q.push_back(64'hfedc_ba98_7654_3210);
        plaintext_q.push_back(64'haaaa_aaaa_aaaa_aaaa);
        plaintext_q.push_back(64'h5555_5555_5555_5555);
        plaintext_q.push_back(64'h8000_0000_0000_0001);
        plaintext_q.push_back(64'h7fff_ffff_ffff_fffe);
        drain_pipe();

        // all-ones key, single round
        set_cipher('1, '1, 64'd1);
        plaintext_q.push_back(64'h0000_0000_0000_0000);
        plaintext_q.push_back(64'hffff_ffff_ffff_ffff);
        queue_random_words(2);
        drain_pipe();

        // zero rounds: ciphertext should equal plaintext
        set_cipher({$urandom, $urandom}, {$urandom, $urandom}, 64'd0);
        plaintext_q.push_back(64'h0000_0000_0000_0000);
        plaintext_q.push_back(64'hffff_ffff_ffff_ffff);
        queue_random_words(2);
        drain_pipe();

        // count of 31 with junk in the upper data bits: clamps to 28
        set_cipher({$urandom, $urandom}, {$urandom, $urandom}, '1);
        plaintext_q.push_back(64'h0000_0000_0000_0000);
        plaintext_q.push_back(64'hffff_ffff_ffff_ffff);
        queue_random_words(2);
        drain_pipe();

        // write to the unused index: nothing should change
        reg_write(ADDR_UNUSED, {$urandom, $urandom});
        plaintext_q.push_back(64'h0000_0000_0000_0000);
        queue_random_words(3);
        drain_pipe();

        // Random phases, each under a fresh key; phase 3 runs with no idling
        // on either side, and the sender pauses at every phase boundary.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            rc = (ph == N_PHASES - 1) ? 5'($urandom_range(0, 31)) : ROUND_PLAN[ph];
            set_cipher({$urandom, $urandom}, {$urandom, $urandom},
                       {{(DW-5){1'b0}}, rc});
            send_idle_pct = (ph == 3) ? 0 : 25;
            recv_idle_pct = (ph == 3) ? 0 : 25;
            queue_random_words(PHASE_WORDS);
            drain_pipe();
        end

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
